// File: src/hpt_pkg.sv
// shared types and constants of the heartbeat peer tracker
package hpt_pkg;

  localparam logic [2:0] OP_HEARTBEAT = 3'd0;
  localparam logic [2:0] OP_CHECK     = 3'd1;
  localparam logic [2:0] OP_SET_COORD = 3'd2;
  localparam logic [2:0] OP_HIGHER    = 3'd3;
  localparam logic [2:0] OP_LOOKUP    = 3'd4;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_OWN      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NOMATCH  = 3'd4;

  localparam logic [1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [1:0] REG_OWN_PRIO = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd3000;
  localparam logic [9:0]  MS_DIV      = 10'd1000;
  localparam logic [4:0]  MAX_RES     = 5'd16;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [47:0] peer_address;
    logic [31:0] peer_priority;
    logic        claims_leader;
    logic        self_is_coordinator;
    logic [47:0] now_us;
    logic [4:0]  max_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        new_peer;
    logic        fire_election;
    logic [47:0] found_address;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] prio;
    logic [47:0] heard;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic fin;
  } cmd_t;

endpackage

// File: src/hpt_ctrl.sv
// controller: sequences load, table scan and finish of one item
module hpt_ctrl #(
  parameter int PEERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output hpt_pkg::cmd_t        cmd,
  output logic [((PEERS > 1) ? $clog2(PEERS) : 1)-1:0] rd_idx
);

  localparam int IW = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int CW = $clog2(PEERS + 1) + 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(PEERS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;

  // state and scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_SCAN;
            cnt_r   <= '0;
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_CNT) state_r <= S_FIN;
        end
        S_FIN: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // commands to the datapath
  assign busy      = (state_r != S_IDLE);
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.rd_en = (state_r == S_SCAN) && (cnt_r < LAST_CNT);
  assign cmd.fin   = (state_r == S_FIN);
  assign rd_idx    = cnt_r[IW-1:0];

endmodule

// File: src/hpt_dp.sv
// datapath: peer table, leader state, scan evaluation and result register
module hpt_dp #(
  parameter int PEERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hpt_pkg::cmd_t        cmd,
  input  logic [((PEERS > 1) ? $clog2(PEERS) : 1)-1:0] rd_idx,
  input  hpt_pkg::in_t         in_data,
  input  logic [47:0]          own_mac,
  input  logic [31:0]          own_prio,
  input  logic [15:0]          timeout_ms,
  output logic                 out_valid,
  output hpt_pkg::out_t        out_data
);

  localparam int IW = (PEERS > 1) ? $clog2(PEERS) : 1;

  hpt_pkg::in_t    item_r;
  logic [26:0]     thr_r;
  logic [PEERS-1:0] used_r;
  hpt_pkg::entry_t mem [PEERS];
  hpt_pkg::entry_t mem_q;
  logic            used_q;
  logic            rd_vld_q;
  logic [IW-1:0]   idx_q;

  logic            fnd_r;
  logic [IW-1:0]   fnd_idx_r;
  hpt_pkg::entry_t fnd_ent_r;
  logic            free_r;
  logic [IW-1:0]   free_idx_r;
  logic            pend_vld_r;
  logic [47:0]     pend_addr_r;
  logic [4:0]      hits_r;

  logic [47:0]     lead_addr_r;
  logic [31:0]     lead_prio_r;
  logic            lead_known_r;
  logic            outage_r;

  logic            out_valid_r;
  hpt_pkg::out_t   out_data_r;

  logic [47:0]     key;
  logic            hit;
  logic            free_hit;
  logic [4:0]      lim;
  logic            hi_hit;
  logic [47:0]     diff;
  logic            expired;
  logic            is_own;
  logic            adopt_hb;
  logic            we;
  logic [IW-1:0]   wa;
  hpt_pkg::entry_t wd;

  // scan evaluation of the entry read in the previous cycle
  assign key = (item_r.opcode == hpt_pkg::OP_CHECK) ? lead_addr_r : item_r.peer_address;
  assign hit = rd_vld_q && used_q &&
               ((item_r.opcode == hpt_pkg::OP_LOOKUP) ? (mem_q.prio == item_r.peer_priority)
                                                       : (mem_q.addr == key));
  assign free_hit = rd_vld_q && !used_q;
  assign lim      = (item_r.max_count > hpt_pkg::MAX_RES) ? hpt_pkg::MAX_RES
                                                          : item_r.max_count;
  assign hi_hit   = rd_vld_q && used_q && (item_r.opcode == hpt_pkg::OP_HIGHER) &&
                    (mem_q.prio > own_prio) && (hits_r < lim);

  // finish decisions
  assign diff     = item_r.now_us - fnd_ent_r.heard;
  assign expired  = !lead_known_r || !fnd_r || (diff >= {21'd0, thr_r});
  assign is_own   = (item_r.peer_address == own_mac);
  assign adopt_hb = item_r.claims_leader &&
                    (!lead_known_r || (item_r.peer_priority >= lead_prio_r));

  // table write on finish
  always_comb begin
    we = 1'b0;
    wa = fnd_r ? fnd_idx_r : free_idx_r;
    wd = '{addr: item_r.peer_address, prio: item_r.peer_priority, heard: item_r.now_us};
    if (cmd.fin) begin
      priority case (item_r.opcode)
        hpt_pkg::OP_HEARTBEAT: we = !is_own && (fnd_r || free_r);
        hpt_pkg::OP_SET_COORD: begin
          we      = fnd_r;
          wd.prio = fnd_ent_r.prio;
        end
        default: we = 1'b0;
      endcase
    end
  end

  // peer table memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    mem_q <= mem[rd_idx];
  end

  // read pipeline and item capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd.rd_en;
    end
    used_q <= used_r[rd_idx];
    idx_q  <= rd_idx;
    if (cmd.load) begin
      item_r <= in_data;
      thr_r  <= 27'(({1'b0, timeout_ms} + 17'd1)) * 27'(hpt_pkg::MS_DIV);
    end
  end

  // scan capture, leader state and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      fnd_r        <= 1'b0;
      free_r       <= 1'b0;
      pend_vld_r   <= 1'b0;
      hits_r       <= '0;
      lead_addr_r  <= '0;
      lead_prio_r  <= '0;
      lead_known_r <= 1'b0;
      outage_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      if (cmd.load) begin
        fnd_r      <= 1'b0;
        free_r     <= 1'b0;
        pend_vld_r <= 1'b0;
        hits_r     <= '0;
      end
      if (hit && !fnd_r) begin
        fnd_r     <= 1'b1;
        fnd_idx_r <= idx_q;
        fnd_ent_r <= mem_q;
      end
      if (free_hit && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_q;
      end
      // higher query: hold one match back so the final one can carry last
      if (hi_hit) begin
        hits_r      <= hits_r + 1'b1;
        pend_vld_r  <= 1'b1;
        pend_addr_r <= mem_q.addr;
        if (pend_vld_r) begin
          out_valid_r              <= 1'b1;
          out_data_r.status        <= hpt_pkg::ST_DONE;
          out_data_r.found_address <= pend_addr_r;
        end
      end
      if (cmd.fin) begin
        out_valid_r     <= 1'b1;
        out_data_r.last <= 1'b1;
        priority case (item_r.opcode)
          hpt_pkg::OP_HEARTBEAT: begin
            if (is_own) begin
              out_data_r.status <= hpt_pkg::ST_OWN;
            end else if (!fnd_r && !free_r) begin
              out_data_r.status <= hpt_pkg::ST_FULL;
            end else begin
              out_data_r.status   <= hpt_pkg::ST_DONE;
              out_data_r.new_peer <= !fnd_r;
              if (!fnd_r) used_r[free_idx_r] <= 1'b1;
              if (adopt_hb) begin
                lead_addr_r  <= item_r.peer_address;
                lead_prio_r  <= item_r.peer_priority;
                lead_known_r <= 1'b1;
                outage_r     <= 1'b0;
              end
            end
          end
          hpt_pkg::OP_CHECK: begin
            out_data_r.status <= hpt_pkg::ST_DONE;
            if (!item_r.self_is_coordinator && expired && !outage_r) begin
              outage_r                 <= 1'b1;
              out_data_r.fire_election <= 1'b1;
            end
          end
          hpt_pkg::OP_SET_COORD: begin
            out_data_r.status <= hpt_pkg::ST_DONE;
            lead_addr_r       <= item_r.peer_address;
            lead_prio_r       <= item_r.peer_priority;
            lead_known_r      <= 1'b1;
            outage_r          <= 1'b0;
          end
          hpt_pkg::OP_HIGHER: begin
            if (pend_vld_r) begin
              out_data_r.status        <= hpt_pkg::ST_DONE;
              out_data_r.found_address <= pend_addr_r;
            end else begin
              out_data_r.status <= hpt_pkg::ST_NOMATCH;
            end
          end
          hpt_pkg::OP_LOOKUP: begin
            if (fnd_r) begin
              out_data_r.status        <= hpt_pkg::ST_DONE;
              out_data_r.found_address <= fnd_ent_r.addr;
            end else begin
              out_data_r.status <= hpt_pkg::ST_NOTFOUND;
            end
          end
          default: out_valid_r <= 1'b0;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/heartbeat_peer_tracker.sv
// top level: configuration registers, controller and datapath
// Every item runs from the accepting edge until busy falls through a read
// of the peer table per entry, a drain of the table read register, and a
// finish step that updates state. The scan of the table memory reads one
// entry a cycle. Each item with a defined opcode gives one result, except
// the higher-priority query, whose results are issued during the scan and
// whose final result comes after it. Results are strobed by out_valid for
// one cycle and cannot be stalled. The user must write configuration over
// the APB-style port only while busy is low; the block does not enforce it.
module heartbeat_peer_tracker #(
  parameter int PEERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hpt_pkg::in_t  in_data,
  output logic          out_valid,
  output hpt_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int IW = (PEERS > 1) ? $clog2(PEERS) : 1;

  logic [47:0]   own_mac_r;
  logic [31:0]   own_prio_r;
  logic [15:0]   timeout_r;
  logic          wr;
  logic [1:0]    reg_idx;
  hpt_pkg::cmd_t cmd;
  logic [IW-1:0] rd_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r  <= '0;
      own_prio_r <= '0;
      timeout_r  <= hpt_pkg::TIMEOUT_RST;
    end else if (wr) begin
      priority case (reg_idx)
        hpt_pkg::REG_OWN_MAC:  own_mac_r  <= pwdata[47:0];
        hpt_pkg::REG_OWN_PRIO: own_prio_r <= pwdata[31:0];
        hpt_pkg::REG_TIMEOUT:  timeout_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    priority case (reg_idx)
      hpt_pkg::REG_OWN_MAC:  prdata = {16'd0, own_mac_r};
      hpt_pkg::REG_OWN_PRIO: prdata = {32'd0, own_prio_r};
      hpt_pkg::REG_TIMEOUT:  prdata = {48'd0, timeout_r};
      default:               prdata = '0;
    endcase
  end

  hpt_ctrl #(.PEERS(PEERS)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .rd_idx (rd_idx)
  );

  hpt_dp #(.PEERS(PEERS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_idx     (rd_idx),
    .in_data    (in_data),
    .own_mac    (own_mac_r),
    .own_prio   (own_prio_r),
    .timeout_ms (timeout_r),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
